[design/llg_magnetization_rate_core_assert.svh]
// Assertion macros for the LLG magnetization rate core.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef LLG_MAGNETIZATION_RATE_CORE_ASSERT_SVH
`define LLG_MAGNETIZATION_RATE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/llg_pkg.sv]
// Package for the LLG magnetization rate core: field widths and defaults.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package llg_pkg;

    // Field widths of the streaming items.
    localparam int LLG_WORD_W   = 32;
    localparam int LLG_ALPHA_W  = 31;
    localparam int LLG_IN_DW    = 224;
    localparam int LLG_OUT_DW   = 96;
    localparam int LLG_CFG_IW   = 2;

    // Default number of fraction bits of the fixed-point format.
    localparam int LLG_FRAC_BITS = 16;

    // Quotient bits produced by the divider; covers every reachable p and q.
    localparam int LLG_QUO_W = 33;

    // Configuration register indexes.
    typedef enum logic [LLG_CFG_IW-1:0] {
        CFG_GYRO_RATIO    = 2'd0,
        CFG_PENALTY_GAIN  = 2'd1,
        CFG_PRECESSION_ON = 2'd2
    } t_cfg_idx;

    typedef logic signed [LLG_WORD_W-1:0] t_word;

    // One accepted input item.
    typedef struct packed {
        t_word [2:0]            mag;
        t_word [2:0]            fld;
        logic [LLG_ALPHA_W-1:0] alpha;
        logic                   pin;
        logic                   last;
    } t_item;

endpackage

`default_nettype wire

[design/llg_magnetization_rate_core.sv]
// Top level of the LLG magnetization rate core: a deep pipeline with a
// pipelined restoring divider for the damping coefficients.
// Depends on llg_pkg and llg_magnetization_rate_core_assert.svh.
//
// An accepted transaction passes the input register, stages 2 to 4, the
// divider stages and tail stages 1 and 2 to reach the output register.
// Throughput: one vertex per cycle unless the output stalls; the divider
// takes one quotient bit per stage, so its stage count sets latency, not rate.
// Reset: synchronous, active low; clears valid bits, the input skid stage and
// the configuration registers (gamma 0, c 0, precession on).
`timescale 1ns / 1ps
`default_nettype none

module llg_magnetization_rate_core #(
    parameter int FRAC_BITS = llg_pkg::LLG_FRAC_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic [llg_pkg::LLG_CFG_IW-1:0] i_cfg_idx,
    input  wire logic [llg_pkg::LLG_WORD_W-1:0] i_cfg_data,
    // Vertex input stream.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: mag_x, mag_y, mag_z, field_x, field_y, field_z,
    // damping (31 bits), one zero pad bit.
    input  wire logic [llg_pkg::LLG_IN_DW-1:0]  s_axis_tdata,
    input  wire logic                           s_axis_tlast,   // last_vertex
    input  wire logic                           s_axis_tuser,   // pinned
    // Rate output stream.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata from bit 0: rate_x, rate_y, rate_z.
    output logic [llg_pkg::LLG_OUT_DW-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast    // last_out
);
    import llg_pkg::*;

    `include "llg_magnetization_rate_core_assert.svh"

    localparam int QB = LLG_QUO_W;
    localparam int NS = 6 + QB;
    localparam logic signed [65:0] HALF_S = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] ONE_S  = 66'sd1 <<< FRAC_BITS;
    localparam logic [63:0]        HALF_U = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0]        ONE_U  = 64'd1 << FRAC_BITS;
    localparam logic signed [65:0] MAX_S  = 66'sd2147483647;
    localparam logic signed [65:0] MIN_S  = -66'sd2147483648;

    typedef struct packed {
        t_word [2:0]        mag;
        logic [2:0][63:0]   pw;
        logic [2:0][63:0]   sq;
        logic [63:0]        a2;
        logic signed [63:0] ga;
        logic               pin;
        logic               last;
    } t_s2;

    typedef struct packed {
        t_word [2:0] mag;
        t_word [2:0] w;
        t_word       e;
        logic [63:0] d;
        logic [63:0] mag_p;
        logic [63:0] mag_q;
        logic        neg;
        logic        pin;
        logic        last;
    } t_s3;

    typedef struct packed {
        t_word [2:0]        mag;
        t_word [2:0]        w;
        logic [2:0][63:0]   pv;
        logic signed [63:0] ce;
        logic [63:0]        d;
        logic [63:0]        num_p;
        logic [63:0]        num_q;
        logic               neg;
        logic               pin;
        logic               last;
    } t_s4;

    typedef struct packed {
        t_word [2:0] mag;
        t_word [2:0] w;
        t_word [2:0] v;
        t_word       k;
        logic        pin;
        logic        last;
    } t_side;

    typedef struct packed {
        logic [63:0]   rem_p;
        logic [63:0]   rem_q;
        logic [QB-1:0] quo_p;
        logic [QB-1:0] quo_q;
        logic [63:0]   d;
        logic          neg;
    } t_div;

    typedef struct packed {
        logic [2:0][63:0] pw;
        logic [2:0][63:0] qv;
        logic [2:0][63:0] km;
        logic             pin;
        logic             last;
    } t_t1;

    // Round half up to the fixed-point grid.
    function automatic logic signed [65:0] rnd(input logic signed [65:0] x);
        rnd = (x + HALF_S) >>> FRAC_BITS;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic t_word sat32(input logic signed [65:0] x);
        if (x > MAX_S) begin
            sat32 = MAX_S[31:0];
        end else if (x < MIN_S) begin
            sat32 = MIN_S[31:0];
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    // Rounded, saturated cross-product component from two exact products.
    function automatic t_word xprod(input logic [63:0] a, input logic [63:0] b);
        xprod = sat32(rnd(66'($signed(a)) - 66'($signed(b))));
    endfunction

    // Apply the sign to a quotient magnitude with saturation.
    function automatic t_word sgn_sat(input logic [QB-1:0] quo, input logic neg);
        logic signed [65:0] wide;
        wide = 66'(quo);
        sgn_sat = neg ? sat32(-wide) : sat32(wide);
    endfunction

    // One restoring division step at quotient bit j.
    function automatic logic [64:0] div_step(input logic [63:0] rem,
                                             input logic [63:0] d, input int j);
        logic [96:0] sh;
        logic        ge;
        sh = 97'(d) << j;
        ge = 97'(rem) >= sh;
        div_step = {ge, ge ? (rem - sh[63:0]) : rem};
    endfunction

    // Configuration registers.
    t_word r_gyro;
    t_word r_pgain;
    logic  r_prec_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro    <= '0;
            r_pgain   <= '0;
            r_prec_on <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GYRO_RATIO:    r_gyro    <= i_cfg_data;
                CFG_PENALTY_GAIN:  r_pgain   <= i_cfg_data;
                CFG_PRECESSION_ON: r_prec_on <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Pipeline control: all stages move together; the skid stage takes one
    // transaction that arrives while the output is stalled.
    logic [NS-1:0] r_vld;
    logic          r_sk_vld;
    t_item         r_sk;
    t_item         w_in;
    t_item         w_src;
    logic          w_src_vld;
    logic          w_en;

    assign w_en          = !r_vld[NS-1] || m_axis_tready;
    assign s_axis_tready = !r_sk_vld;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in.mag[i] = s_axis_tdata[32*i +: 32];
            w_in.fld[i] = s_axis_tdata[96 + 32*i +: 32];
        end
        w_in.alpha = s_axis_tdata[192 +: LLG_ALPHA_W];
        w_in.pin   = s_axis_tuser;
        w_in.last  = s_axis_tlast;
    end

    assign w_src     = r_sk_vld ? r_sk : w_in;
    assign w_src_vld = r_sk_vld || s_axis_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            if (w_en) begin
                r_sk_vld <= 1'b0;
                r_vld    <= {r_vld[NS-2:0], w_src_vld};
            end else if (s_axis_tvalid && !r_sk_vld) begin
                r_sk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && s_axis_tvalid && !r_sk_vld) begin
            r_sk <= w_in;
        end
    end

    // Stage 1: input register.
    t_item r_s1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= w_src;
        end
    end

    // Stage 2: first products (cross terms of M x H, squares, alpha terms).
    t_s2 r_s2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2.mag   <= r_s1.mag;
            r_s2.pw[0] <= $signed(r_s1.mag[1]) * $signed(r_s1.fld[2]);
            r_s2.pw[1] <= $signed(r_s1.mag[2]) * $signed(r_s1.fld[1]);
            r_s2.pw[2] <= $signed(r_s1.mag[2]) * $signed(r_s1.fld[0]);
            for (int i = 0; i < 3; i++) begin
                r_s2.sq[i] <= $signed(r_s1.mag[i]) * $signed(r_s1.mag[i]);
            end
            r_s2.a2   <= 64'(r_s1.alpha) * 64'(r_s1.alpha);
            r_s2.ga   <= $signed(r_gyro) * $signed({1'b0, r_s1.alpha});
            r_s2.pin  <= r_s1.pin;
            r_s2.last <= r_s1.last;
        end
    end

    // The other three cross terms are multiplied beside the first three.
    logic [2:0][63:0] r_s2_pw_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_pw_b[0] <= $signed(r_s1.mag[0]) * $signed(r_s1.fld[2]);
            r_s2_pw_b[1] <= $signed(r_s1.mag[0]) * $signed(r_s1.fld[1]);
            r_s2_pw_b[2] <= $signed(r_s1.mag[1]) * $signed(r_s1.fld[0]);
        end
    end

    // Stage 3: w = M x H, norm error, divisor and dividend magnitudes.
    t_s3         r_s3;
    logic [63:0] w_sqsum;
    logic [63:0] w_msq;
    logic [63:0] w_gabs;
    assign w_sqsum = r_s2.sq[0] + r_s2.sq[1] + r_s2.sq[2];
    assign w_msq   = (w_sqsum + HALF_U) >> FRAC_BITS;
    assign w_gabs  = r_gyro[31] ? (64'd0 - 64'($signed(r_gyro))) : 64'(r_gyro);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3.mag   <= r_s2.mag;
            r_s3.w[0]  <= xprod(r_s2.pw[0], r_s2.pw[1]);
            r_s3.w[1]  <= xprod(r_s2.pw[2], r_s2_pw_b[0]);
            r_s3.w[2]  <= xprod(r_s2_pw_b[1], r_s2_pw_b[2]);
            r_s3.e     <= sat32($signed({2'b00, w_msq}) - ONE_S);
            r_s3.d     <= ONE_U + ((r_s2.a2 + HALF_U) >> FRAC_BITS);
            r_s3.mag_p <= w_gabs << FRAC_BITS;
            r_s3.mag_q <= r_s2.ga[63] ? (64'd0 - r_s2.ga) : r_s2.ga;
            r_s3.neg   <= r_gyro[31];
            r_s3.pin   <= r_s2.pin;
            r_s3.last  <= r_s2.last;
        end
    end

    // Stage 4: products for M x w and c*e; rounded dividends.
    t_s4 r_s4;
    logic [2:0][63:0] r_s4_pv_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4.mag      <= r_s3.mag;
            r_s4.w        <= r_s3.w;
            r_s4.pv[0]    <= $signed(r_s3.mag[1]) * $signed(r_s3.w[2]);
            r_s4.pv[1]    <= $signed(r_s3.mag[2]) * $signed(r_s3.w[0]);
            r_s4.pv[2]    <= $signed(r_s3.mag[0]) * $signed(r_s3.w[1]);
            r_s4_pv_b[0]  <= $signed(r_s3.mag[2]) * $signed(r_s3.w[1]);
            r_s4_pv_b[1]  <= $signed(r_s3.mag[0]) * $signed(r_s3.w[2]);
            r_s4_pv_b[2]  <= $signed(r_s3.mag[1]) * $signed(r_s3.w[0]);
            r_s4.ce       <= $signed(r_pgain) * $signed(r_s3.e);
            r_s4.d        <= r_s3.d;
            r_s4.num_p    <= r_s3.mag_p + (r_s3.d >> 1);
            r_s4.num_q    <= r_s3.mag_q + (r_s3.d >> 1);
            r_s4.neg      <= r_s3.neg;
            r_s4.pin      <= r_s3.pin;
            r_s4.last     <= r_s3.last;
        end
    end

    // Divider pipeline, one quotient bit per stage, with the side data
    // travelling beside it.
    t_div  r_dv [QB];
    t_side r_sd [QB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0].mag  <= r_s4.mag;
            r_sd[0].w    <= r_s4.w;
            r_sd[0].v[0] <= xprod(r_s4.pv[0], r_s4_pv_b[0]);
            r_sd[0].v[1] <= xprod(r_s4.pv[1], r_s4_pv_b[1]);
            r_sd[0].v[2] <= xprod(r_s4.pv[2], r_s4_pv_b[2]);
            r_sd[0].k    <= sat32(rnd(66'(r_s4.ce)));
            r_sd[0].pin  <= r_s4.pin;
            r_sd[0].last <= r_s4.last;
        end
    end

    logic [64:0] w_st_p [QB];
    logic [64:0] w_st_q [QB];

    assign w_st_p[0] = div_step(r_s4.num_p, r_s4.d, QB - 1);
    assign w_st_q[0] = div_step(r_s4.num_q, r_s4.d, QB - 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0].rem_p <= w_st_p[0][63:0];
            r_dv[0].rem_q <= w_st_q[0][63:0];
            r_dv[0].quo_p <= QB'(w_st_p[0][64]);
            r_dv[0].quo_q <= QB'(w_st_q[0][64]);
            r_dv[0].d     <= r_s4.d;
            r_dv[0].neg   <= r_s4.neg;
        end
    end

    for (genvar g = 1; g < QB; g++) begin : g_div
        assign w_st_p[g] = div_step(r_dv[g-1].rem_p, r_dv[g-1].d, QB - 1 - g);
        assign w_st_q[g] = div_step(r_dv[g-1].rem_q, r_dv[g-1].d, QB - 1 - g);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[g].rem_p <= w_st_p[g][63:0];
                r_dv[g].rem_q <= w_st_q[g][63:0];
                r_dv[g].quo_p <= {r_dv[g-1].quo_p[QB-2:0], w_st_p[g][64]};
                r_dv[g].quo_q <= {r_dv[g-1].quo_q[QB-2:0], w_st_q[g][64]};
                r_dv[g].d     <= r_dv[g-1].d;
                r_dv[g].neg   <= r_dv[g-1].neg;
                r_sd[g]       <= r_sd[g-1];
            end
        end
    end

    // Tail stage 1: coefficient products p*w, q*v and k*M.
    t_side w_sl;
    t_word w_p;
    t_word w_q;
    t_t1   r_t1;
    assign w_sl = r_sd[QB-1];
    assign w_p  = r_prec_on ? sgn_sat(r_dv[QB-1].quo_p, r_dv[QB-1].neg) : '0;
    assign w_q  = sgn_sat(r_dv[QB-1].quo_q, r_dv[QB-1].neg);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t1.pw[i] <= $signed(w_p) * $signed(w_sl.w[i]);
                r_t1.qv[i] <= $signed(w_q) * $signed(w_sl.v[i]);
                r_t1.km[i] <= $signed(w_sl.k) * $signed(w_sl.mag[i]);
            end
            r_t1.pin  <= w_sl.pin;
            r_t1.last <= w_sl.last;
        end
    end

    // Tail stage 2: sum, negate and saturate into the output register; pinned vertices give zero.
    t_word [2:0] r_out;
    logic        r_out_last;
    logic        r_out_pin;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= r_t1.pin ? '0 :
                    sat32(-(rnd(66'($signed(r_t1.pw[i]))) + rnd(66'($signed(r_t1.qv[i])))
                            + rnd(66'($signed(r_t1.km[i])))));
            end
            r_out_last <= r_t1.last;
            r_out_pin  <= r_t1.pin;
        end
    end

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tlast  = r_out_last;

    // Checks on the pipeline control and the datapath.
    `LLG_ASSERT_NEXT(a_stall_holds_valid, !w_en, $stable(r_vld),
        "valid bits moved during a stall")
    `LLG_ASSERT_NEXT(a_skid_kept, r_sk_vld && !w_en, r_sk_vld,
        "skid transaction dropped during a stall")
    `LLG_ASSERT_NOW(a_pinned_zero, r_vld[NS-1] && r_out_pin, m_axis_tdata == '0,
        "pinned vertex gave a nonzero rate")
    `LLG_ASSERT_NOW(a_div_rem, r_vld[NS-3],
        (r_dv[QB-1].rem_p < r_dv[QB-1].d) && (r_dv[QB-1].rem_q < r_dv[QB-1].d),
        "divider remainder not below divisor")

endmodule

`default_nettype wire
